// File: rtl/ece_pkg.sv
package ece_pkg;

  localparam int FRAC_BITS = 15;
  localparam int XW        = FRAC_BITS + 1;
  localparam int OUT_W     = 16;
  localparam int MODE_W    = 5;
  localparam logic [MODE_W-1:0] MODE_LAST = 5'd16;

  localparam logic [XW-1:0] ONE  = XW'(1) << FRAC_BITS;
  localparam logic [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);

  localparam int Q30 = 30;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam int SINE_STEPS   = 7;
  localparam int RECIP_SHIFT  = 35;
  localparam logic [35:0] RECIP_SCALE = 36'd1 << RECIP_SHIFT;
  localparam logic [7:0] SINE_DIV [SINE_STEPS] = '{
    8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182, 8'd240
  };
  localparam logic [31:0] SINE_RECIP [SINE_STEPS] = '{
    32'(RECIP_SCALE / 12), 32'(RECIP_SCALE / 30), 32'(RECIP_SCALE / 56),
    32'(RECIP_SCALE / 90), 32'(RECIP_SCALE / 132), 32'(RECIP_SCALE / 182),
    32'(RECIP_SCALE / 240)
  };

  // Register stages from the argument register to the base curve result.
  localparam int BASE_LAT = 24;

  typedef enum logic [1:0] {
    KIND_QUAD,
    KIND_CUBIC,
    KIND_SINE,
    KIND_CIRC
  } kind_t;

  typedef enum logic [1:0] {
    FORM_IN,
    FORM_OUT,
    FORM_INOUT,
    FORM_OUTIN
  } form_t;

  typedef struct packed {
    logic          valid;
    logic          linear;
    logic          inv;
    logic          halve;
    logic          add_half;
    kind_t         kind;
    logic [XW-1:0] x;
  } ctrl_t;

endpackage

// File: rtl/ece_poly.sv
module ece_poly (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ece_pkg::XW-1:0]    xb,
  output logic [ece_pkg::XW-1:0]    quad,
  output logic [ece_pkg::XW-1:0]    cube
);

  localparam int PAD = ece_pkg::BASE_LAT - 2;
  localparam logic [2*ece_pkg::XW-1:0] RND = (2*ece_pkg::XW)'(1) << (ece_pkg::FRAC_BITS - 1);

  logic [ece_pkg::XW-1:0] sq_r, xb1_r;
  logic [ece_pkg::XW-1:0] sq2_r, cube_r;
  logic [ece_pkg::XW-1:0] quad_d_r [PAD];
  logic [ece_pkg::XW-1:0] cube_d_r [PAD];
  logic [2*ece_pkg::XW-1:0] sq_full, cube_full;

  always_comb begin
    sq_full   = (2*ece_pkg::XW)'(xb) * (2*ece_pkg::XW)'(xb) + RND;
    cube_full = (2*ece_pkg::XW)'(sq_r) * (2*ece_pkg::XW)'(xb1_r) + RND;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r     <= ece_pkg::XW'(sq_full >> ece_pkg::FRAC_BITS);
      xb1_r    <= xb;
      sq2_r    <= sq_r;
      cube_r   <= ece_pkg::XW'(cube_full >> ece_pkg::FRAC_BITS);
      quad_d_r[0] <= sq2_r;
      cube_d_r[0] <= cube_r;
      for (int i = 1; i < PAD; i++) begin
        quad_d_r[i] <= quad_d_r[i-1];
        cube_d_r[i] <= cube_d_r[i-1];
      end
    end
  end

  assign quad = quad_d_r[PAD-1];
  assign cube = cube_d_r[PAD-1];

endmodule

// File: rtl/ece_sine.sv
module ece_sine (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ece_pkg::XW-1:0]    xb,
  output logic [ece_pkg::XW-1:0]    result
);

  localparam int N = ece_pkg::SINE_STEPS;
  localparam logic [47:0] TH_RND  = 48'd1 << (ece_pkg::FRAC_BITS - 1);
  localparam logic [63:0] SQ_RND  = 64'd1 << (ece_pkg::Q30 - 1);
  localparam logic [32:0] SUM_MAX = 33'd1 << ece_pkg::Q30;
  localparam logic [32:0] OUT_RND = 33'd1 << (ece_pkg::Q30 - ece_pkg::FRAC_BITS - 1);

  logic [30:0] th_r;
  logic [31:0] th2_c_r  [N+1];
  logic [31:0] term_c_r [N+1];
  logic [32:0] sum_c_r  [N+1];
  logic [63:0] prod_a_r [N];
  logic [31:0] th2_a_r  [N];
  logic [32:0] sum_a_r  [N];
  logic [31:0] n_b_r    [N];
  logic [63:0] qe_b_r   [N];
  logic [31:0] th2_b_r  [N];
  logic [32:0] sum_b_r  [N];
  logic [ece_pkg::XW-1:0] result_r;

  logic [47:0] th_full;
  logic [63:0] th_sq;
  logic [31:0] th2_nxt;
  logic [32:0] sum_clamp;
  logic [32:0] sum_rnd;

  always_comb begin
    th_full   = 48'(xb) * 48'(ece_pkg::HALF_PI_Q30) + TH_RND;
    th_sq     = 64'(th_r) * 64'(th_r) + SQ_RND;
    th2_nxt   = 32'(th_sq >> ece_pkg::Q30);
    sum_clamp = (sum_c_r[N] > SUM_MAX) ? SUM_MAX : sum_c_r[N];
    sum_rnd   = (sum_clamp + OUT_RND) >> (ece_pkg::Q30 - ece_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_r        <= 31'(th_full >> ece_pkg::FRAC_BITS);
      th2_c_r[0]  <= th2_nxt;
      term_c_r[0] <= th2_nxt >> 1;
      sum_c_r[0]  <= 33'(th2_nxt >> 1);
      result_r    <= ece_pkg::XW'(sum_rnd);
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [28:0] q_est;
    logic [36:0] q_mul;
    logic [31:0] rem;
    logic [31:0] term_nxt;
    logic [32:0] sum_nxt;

    always_comb begin
      q_est    = 29'(qe_b_r[j] >> ece_pkg::RECIP_SHIFT);
      q_mul    = 37'(q_est) * 37'(ece_pkg::SINE_DIV[j]);
      rem      = n_b_r[j] - q_mul[31:0];
      term_nxt = (rem >= 32'(ece_pkg::SINE_DIV[j])) ? 32'(q_est) + 32'd1 : 32'(q_est);
      if (j % 2 == 0) begin
        sum_nxt = sum_b_r[j] - 33'(term_nxt);
      end else begin
        sum_nxt = sum_b_r[j] + 33'(term_nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod_a_r[j]   <= 64'(term_c_r[j]) * 64'(th2_c_r[j]);
        th2_a_r[j]    <= th2_c_r[j];
        sum_a_r[j]    <= sum_c_r[j];
        n_b_r[j]      <= 32'(prod_a_r[j] >> ece_pkg::Q30);
        qe_b_r[j]     <= 64'(32'(prod_a_r[j] >> ece_pkg::Q30)) * 64'(ece_pkg::SINE_RECIP[j]);
        th2_b_r[j]    <= th2_a_r[j];
        sum_b_r[j]    <= sum_a_r[j];
        term_c_r[j+1] <= term_nxt;
        sum_c_r[j+1]  <= sum_nxt;
        th2_c_r[j+1]  <= th2_b_r[j];
      end
    end
  end

  assign result = result_r;

endmodule

// File: rtl/ece_circ.sv
module ece_circ (
  input  logic                      clk,
  input  logic                      en,
  input  logic [ece_pkg::XW-1:0]    xb,
  output logic [ece_pkg::XW-1:0]    result
);

  localparam int S   = ece_pkg::XW;
  localparam int PAD = ece_pkg::BASE_LAT - S - 2;
  localparam logic [31:0] ONE_SQ = 32'd1 << (2 * ece_pkg::FRAC_BITS);

  logic [31:0] rem_r [S+1];
  logic [S:0]  res_r [S+1];
  logic [ece_pkg::XW-1:0] out_r;
  logic [ece_pkg::XW-1:0] pad_r [PAD];
  logic [31:0] xx;
  logic [S:0]  res_rnd;

  always_comb begin
    xx      = 32'(xb) * 32'(xb);
    res_rnd = (rem_r[S] > 32'(res_r[S])) ? res_r[S] + 1'b1 : res_r[S];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ONE_SQ - xx;
      res_r[0] <= '0;
      out_r    <= ece_pkg::XW'((S+1)'(ece_pkg::ONE) - res_rnd);
      pad_r[0] <= out_r;
      for (int i = 1; i < PAD; i++) begin
        pad_r[i] <= pad_r[i-1];
      end
    end
  end

  for (genvar s = 0; s < S; s++) begin : g_bit
    localparam int B = S - 1 - s;
    logic [31:0] trial;

    always_comb begin
      trial = (32'(res_r[s]) << (B + 1)) + (32'd1 << (2 * B));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_r[s] >= trial) begin
          rem_r[s+1] <= rem_r[s] - trial;
          res_r[s+1] <= res_r[s] + ((S+1)'(1) << B);
        end else begin
          rem_r[s+1] <= rem_r[s];
          res_r[s+1] <= res_r[s];
        end
      end
    end
  end

  assign result = pad_r[PAD-1];

endmodule

// File: rtl/easing_curve_evaluator.sv
// Evaluates easing curves on Q1.15 progress words, one word per clock cycle
// when the output is not stalled. Each accepted word passes an input register,
// a 24-stage base curve datapath (the sine series of seven multiply and divide
// steps at three stages each sets this depth) and an output register.
// Quadratic, cubic and circular curves run through padded pipelines of the
// same depth, so results keep their order. A stall holds every stage at once.
// The curve mode register must be written only while no word is in flight.
module easing_curve_evaluator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [15:0]                   in_progress,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ece_pkg::OUT_W-1:0]     out_eased_value,
  input  logic                          cfg_wr_en,
  input  logic [ece_pkg::MODE_W-1:0]    cfg_wr_data
);

  localparam int L  = ece_pkg::BASE_LAT;
  localparam int XW = ece_pkg::XW;

  logic [ece_pkg::MODE_W-1:0] curve_mode_r;
  ece_pkg::ctrl_t ctrl_r [L+1];
  ece_pkg::ctrl_t ctrl_nxt;
  logic [XW-1:0] xb_r, xb_nxt;
  logic          out_valid_r;
  logic [XW-1:0] out_eased_value_r, value_nxt;
  logic          en;

  logic [XW-1:0] quad, cube, sine_r, circ_r;
  logic [ece_pkg::MODE_W-1:0] mode_m1;
  ece_pkg::form_t form;
  logic [XW-1:0] x_sat;
  logic [XW:0]   dbl;
  logic          lower;
  logic [XW-1:0] r_sel, r_c;
  logic [XW:0]   v;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_comb begin
    x_sat   = (in_progress > 16'(ece_pkg::ONE)) ? ece_pkg::ONE : XW'(in_progress);
    dbl     = {x_sat, 1'b0};
    lower   = x_sat < ece_pkg::HALF;
    mode_m1 = curve_mode_r - 1'b1;
    form    = ece_pkg::form_t'(mode_m1[1:0]);

    ctrl_nxt          = '0;
    ctrl_nxt.valid    = in_valid;
    ctrl_nxt.x        = x_sat;
    ctrl_nxt.kind     = ece_pkg::kind_t'(mode_m1[3:2]);
    ctrl_nxt.linear   = (curve_mode_r == '0) || (curve_mode_r > ece_pkg::MODE_LAST);
    xb_nxt            = x_sat;
    if (!ctrl_nxt.linear) begin
      unique case (form)
        ece_pkg::FORM_IN: begin
          xb_nxt = x_sat;
        end
        ece_pkg::FORM_OUT: begin
          xb_nxt       = ece_pkg::ONE - x_sat;
          ctrl_nxt.inv = 1'b1;
        end
        ece_pkg::FORM_INOUT: begin
          ctrl_nxt.halve = 1'b1;
          if (lower) begin
            xb_nxt = dbl[XW-1:0];
          end else begin
            xb_nxt            = XW'({ece_pkg::ONE, 1'b0} - dbl);
            ctrl_nxt.inv      = 1'b1;
            ctrl_nxt.add_half = 1'b1;
          end
        end
        ece_pkg::FORM_OUTIN: begin
          ctrl_nxt.halve = 1'b1;
          if (lower) begin
            xb_nxt       = XW'((XW+1)'(ece_pkg::ONE) - dbl);
            ctrl_nxt.inv = 1'b1;
          end else begin
            xb_nxt            = XW'(dbl - (XW+1)'(ece_pkg::ONE));
            ctrl_nxt.add_half = 1'b1;
          end
        end
        default: begin
          xb_nxt = x_sat;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_mode_r <= '0;
    end else if (cfg_wr_en) begin
      curve_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= L; i++) begin
        ctrl_r[i].valid <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      ctrl_r[0] <= ctrl_nxt;
      for (int i = 1; i <= L; i++) begin
        ctrl_r[i] <= ctrl_r[i-1];
      end
      out_valid_r <= ctrl_r[L].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xb_r              <= xb_nxt;
      out_eased_value_r <= value_nxt;
    end
  end

  ece_poly u_poly (.clk(clk), .en(en), .xb(xb_r), .quad(quad), .cube(cube));
  ece_sine u_sine (.clk(clk), .en(en), .xb(xb_r), .result(sine_r));
  ece_circ u_circ (.clk(clk), .en(en), .xb(xb_r), .result(circ_r));

  always_comb begin
    unique case (ctrl_r[L].kind)
      ece_pkg::KIND_QUAD:  r_sel = quad;
      ece_pkg::KIND_CUBIC: r_sel = cube;
      ece_pkg::KIND_SINE:  r_sel = sine_r;
      ece_pkg::KIND_CIRC:  r_sel = circ_r;
      default:             r_sel = quad;
    endcase
    r_c = (r_sel > ece_pkg::ONE) ? ece_pkg::ONE : r_sel;
    v   = ctrl_r[L].inv ? (XW+1)'(ece_pkg::ONE - r_c) : (XW+1)'(r_c);
    if (ctrl_r[L].halve) begin
      v = (v + 1'b1) >> 1;
    end
    if (ctrl_r[L].add_half) begin
      v = v + (XW+1)'(ece_pkg::HALF);
    end
    if (ctrl_r[L].linear) begin
      v = (XW+1)'(ctrl_r[L].x);
    end
    value_nxt = (v > (XW+1)'(ece_pkg::ONE)) ? ece_pkg::ONE : v[XW-1:0];
  end

  assign out_valid       = out_valid_r;
  assign out_eased_value = ece_pkg::OUT_W'(out_eased_value_r);

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_eased_value_r <= ece_pkg::ONE)
    else $error("eased value above one");

  a_low_half: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ctrl_r[L].valid && ctrl_r[L].halve && !ctrl_r[L].add_half)
      |=> out_eased_value_r <= ece_pkg::HALF)
    else $error("lower half result above one half");

  a_high_half: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ctrl_r[L].valid && ctrl_r[L].add_half)
      |=> out_eased_value_r >= ece_pkg::HALF)
    else $error("upper half result below one half");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctrl_r[L].valid) && $stable(out_valid_r))
    else $error("pipeline moved during stall");

endmodule

// File: dv/tb_easing_curve_evaluator.sv
module tb_easing_curve_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 26;
  localparam int IDLE_LIMIT = 4000;
  localparam int N_RANDOM   = 700;

  localparam logic [4:0] MODE_LINEAR  = 5'd0;
  localparam logic [4:0] MODE_QUAD_IN = 5'd1;
  localparam logic [4:0] MODE_CIRC_OI = 5'd16;

  typedef struct {
    logic [4:0]  mode;
    logic [15:0] progress;
    logic        known;
    logic [15:0] value;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_progress = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ece_pkg::OUT_W-1:0] out_eased_value;
  logic cfg_wr_en = 1'b0;
  logic [ece_pkg::MODE_W-1:0] cfg_wr_data = '0;

  logic [4:0] mode_now;
  logic [15:0] expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  int idle_pct = 29;

  easing_curve_evaluator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_progress(in_progress),
    .out_valid(out_valid), .out_stall(out_stall), .out_eased_value(out_eased_value),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << (ece_pkg::FRAC_BITS - 1))) >> ece_pkg::FRAC_BITS;
  endfunction

  function automatic longint unsigned root_nearest(longint unsigned d);
    longint unsigned r, sq;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      sq = (r | (64'd1 << b)) * (r | (64'd1 << b));
      if (sq <= d) r = r | (64'd1 << b);
    end
    if (d - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic longint unsigned one_minus_cos(longint unsigned x);
    longint unsigned ang, ang2, term, acc;
    ang = ((x << (ece_pkg::Q30 - ece_pkg::FRAC_BITS)) * 64'd1686629713
           + (64'd1 << (ece_pkg::Q30 - 1))) >> ece_pkg::Q30;
    ang2 = (ang * ang + (64'd1 << (ece_pkg::Q30 - 1))) >> ece_pkg::Q30;
    term = ang2 >> 1;
    acc = term;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * ang2) >> ece_pkg::Q30) / ((2 * k + 1) * (2 * k + 2));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    if (acc > (64'd1 << ece_pkg::Q30)) acc = 64'd1 << ece_pkg::Q30;
    return (acc + (64'd1 << (ece_pkg::Q30 - ece_pkg::FRAC_BITS - 1)))
           >> (ece_pkg::Q30 - ece_pkg::FRAC_BITS);
  endfunction

  function automatic longint unsigned shape(ece_pkg::kind_t kind, longint unsigned x);
    longint unsigned one, r;
    one = 64'd1 << ece_pkg::FRAC_BITS;
    if (x > one) x = one;
    case (kind)
      ece_pkg::KIND_QUAD:  r = fx_mul(x, x);
      ece_pkg::KIND_CUBIC: r = fx_mul(fx_mul(x, x), x);
      ece_pkg::KIND_SINE:  r = one_minus_cos(x);
      default:             r = one - root_nearest(one * one - x * x);
    endcase
    if (r > one) r = one;
    return r;
  endfunction

  function automatic logic [15:0] eased(logic [4:0] mode, logic [15:0] p);
    longint unsigned one, half, x, y;
    ece_pkg::kind_t kind;
    ece_pkg::form_t form;
    one = 64'd1 << ece_pkg::FRAC_BITS;
    half = one >> 1;
    x = p;
    if (x > one) x = one;
    if (mode == MODE_LINEAR || mode > ece_pkg::MODE_LAST) begin
      y = x;
    end else begin
      kind = ece_pkg::kind_t'((mode - 1) / 4);
      form = ece_pkg::form_t'((mode - 1) % 4);
      case (form)
        ece_pkg::FORM_IN:  y = shape(kind, x);
        ece_pkg::FORM_OUT: y = one - shape(kind, one - x);
        ece_pkg::FORM_INOUT: begin
          if (x < half) y = (shape(kind, 2 * x) + 1) >> 1;
          else y = half + ((one - shape(kind, one - (2 * x - one)) + 1) >> 1);
        end
        default: begin
          if (x < half) y = (one - shape(kind, one - 2 * x) + 1) >> 1;
          else y = half + ((shape(kind, 2 * x - one) + 1) >> 1);
        end
      endcase
    end
    if (y > one) y = one;
    return y[15:0];
  endfunction

  task automatic send_word(logic [15:0] p, logic known, logic [15:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_progress <= p;
    expected_q.push_back(known ? value : eased(mode_now, p));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_and_write(logic [4:0] mode);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    mode_now = mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d", $time, out_eased_value);
        errors++;
      end else begin
        if (out_eased_value !== expected_q[0]) begin
          $display("%0t: eased_value mismatch, expected %0d, actual %0d",
                   $time, expected_q[0], out_eased_value);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_easing_curve_evaluator: done, errors");
      $finish;
    end
  end

  vector_t directed[] = '{
    '{MODE_LINEAR, 16'd0, 1'b1, 16'd0},
    '{MODE_LINEAR, 16'd12345, 1'b1, 16'd12345},
    '{MODE_LINEAR, 16'd32768, 1'b1, 16'd32768},
    '{MODE_LINEAR, 16'hFFFF, 1'b1, 16'd32768},
    '{MODE_QUAD_IN, 16'd0, 1'b1, 16'd0},
    '{MODE_QUAD_IN, 16'd16384, 1'b1, 16'd8192},
    '{MODE_QUAD_IN, 16'hFFFF, 1'b1, 16'd32768},
    '{5'd6, 16'd32768, 1'b1, 16'd32768},
    '{5'd7, 16'd16383, 1'b0, 16'd0},
    '{5'd7, 16'd16384, 1'b0, 16'd0},
    '{5'd8, 16'd16384, 1'b0, 16'd0},
    '{5'd9, 16'd32768, 1'b0, 16'd0},
    '{5'd10, 16'd1, 1'b0, 16'd0},
    '{5'd11, 16'd20000, 1'b0, 16'd0},
    '{5'd12, 16'd40000, 1'b0, 16'd0},
    '{5'd13, 16'd32767, 1'b0, 16'd0},
    '{5'd14, 16'd1, 1'b0, 16'd0},
    '{5'd15, 16'd16384, 1'b0, 16'd0},
    '{MODE_CIRC_OI, 16'd0, 1'b0, 16'd0},
    '{MODE_CIRC_OI, 16'd32768, 1'b1, 16'd32768},
    '{5'd17, 16'd5000, 1'b1, 16'd5000},
    '{5'd31, 16'hFFFF, 1'b1, 16'd32768}
  };

  initial begin
    logic [15:0] p;
    logic [4:0] m;
    mode_now = MODE_LINEAR;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].mode != mode_now) drain_and_write(directed[i].mode);
      send_word(directed[i].progress, directed[i].known, directed[i].value);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 35 == 0) begin
        m = (n % 140 == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
        drain_and_write(m);
      end
      if (n == 210) idle_pct = 0;
      if (n == 320) idle_pct = 29;
      if (n == 400) hold_cycles = 200;
      if (n == 500) begin
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      case ($urandom_range(9))
        0: p = 16'($urandom_range(65535));
        1: p = 16'($urandom_range(32768, 32760));
        2: p = 16'($urandom_range(16390, 16378));
        3: p = 16'($urandom_range(8));
        default: p = 16'($urandom_range(32768));
      endcase
      send_word(p, 1'b0, 16'd0);
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_easing_curve_evaluator: done, clean");
    end else begin
      $display("tb_easing_curve_evaluator: done, errors");
    end
    $finish;
  end
endmodule
